// File: design/stereo_allpass_diffuser_macros.svh
// Assertion macros shared by the stereo allpass diffuser modules.
`ifndef STEREO_ALLPASS_DIFFUSER_MACROS_SVH
`define STEREO_ALLPASS_DIFFUSER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SAPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a result in the next cycle.
`define SAPD_ASSERT_NEXT(name, cond, nxt, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// File: design/sapd_pkg.sv
// Shared constants, tables, types and elaboration functions of the diffuser.
package sapd_pkg;

  // Structure of the cascade.
  localparam int MAX_STAGES      = 6;
  localparam int STAGE_W         = $clog2(MAX_STAGES);
  localparam int COEF_BITS       = 16;
  localparam int TIME_SUM_MAX    = 3546;
  localparam int SPARE_PER_STAGE = 64;

  // Channel indexes.
  localparam int CH_LEFT  = 0;
  localparam int CH_RIGHT = 1;

  // Defaults of the top-level parameters.
  localparam int DEF_SAMPLE_RATE_HZ = 48000;
  localparam int DEF_STAGE_COUNT    = 6;
  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_FRACTION_BITS  = 21;

  // Stage times in hundredths of a millisecond, per channel.
  localparam int unsigned TIME_CMS [2][MAX_STAGES] = '{
    '{157, 253, 389, 583, 847, 1253},
    '{167, 263, 401, 589, 859, 1267}
  };

  // Allpass gains in percent, per channel.
  localparam int unsigned COEF_PCT [2][MAX_STAGES] = '{
    '{65, 62, 59, 56, 53, 50},
    '{63, 60, 58, 55, 52, 49}
  };

  // Handshake status that a lane reports to the merge stage.
  typedef struct packed {
    logic idle;
    logic full;
  } sapd_lane_stat_t;

  // Total store size that the delay lines of one channel may take.
  function automatic int unsigned sapd_store_limit(input int unsigned rate);
    return (TIME_SUM_MAX * rate) / 100000 + MAX_STAGES * SPARE_PER_STAGE;
  endfunction

  // Primality test by stepping through multiples, used at elaboration only.
  function automatic bit sapd_is_prime(input int unsigned v);
    int unsigned d;
    int unsigned m;
    bit          prime;
    if (v < 2) return 1'b0;
    if (v == 2) return 1'b1;
    if (v[0] == 1'b0) return 1'b0;
    prime = 1'b1;
    for (d = 3; d * d <= v; d += 2) begin
      m = d * d;
      while (m < v) m += d;
      if (m == v) prime = 1'b0;
    end
    return prime;
  endfunction

  // Nearest odd prime, searching downward first at each distance.
  function automatic int unsigned sapd_odd_prime(input int unsigned n);
    int unsigned v;
    int unsigned off;
    v = (n < 3) ? 3 : n;
    if (v[0] == 1'b0) v++;
    for (off = 0; off < v; off += 2) begin
      if ((v - off) >= 3 && sapd_is_prime(v - off)) return v - off;
      if (off != 0 && sapd_is_prime(v + off)) return v + off;
    end
    return v;
  endfunction

  // Length or base address of one delay line inside its channel store.
  function automatic int unsigned sapd_line(input int ch, input int stage,
                                            input int unsigned rate, input bit want_base);
    int unsigned used;
    int unsigned n;
    int unsigned d;
    int unsigned limit;
    int          s;
    used  = 0;
    limit = sapd_store_limit(rate);
    for (s = 0; s <= stage; s++) begin
      n = (TIME_CMS[ch][s] * rate + 50000) / 100000;
      d = sapd_odd_prime(n);
      if (used + d > limit) d = (limit > used) ? limit - used : 0;
      if (d == 0) d = 1;
      if (s == stage) return want_base ? used : d;
      used += d;
    end
    return 0;
  endfunction

  function automatic int unsigned sapd_line_len(input int ch, input int stage,
                                                input int unsigned rate);
    return sapd_line(ch, stage, rate, 1'b0);
  endfunction

  function automatic int unsigned sapd_line_base(input int ch, input int stage,
                                                 input int unsigned rate);
    return sapd_line(ch, stage, rate, 1'b1);
  endfunction

  // Longest line among the stages in use.
  function automatic int unsigned sapd_max_len(input int ch, input int unsigned rate,
                                               input int stages);
    int unsigned m;
    int          s;
    m = 1;
    for (s = 0; s < stages; s++) begin
      if (sapd_line_len(ch, s, rate) > m) m = sapd_line_len(ch, s, rate);
    end
    return m;
  endfunction

  // Unsigned Q0.16 gain, rounded half up from the percent table.
  function automatic logic [COEF_BITS-1:0] sapd_coef(input int ch, input int stage);
    return COEF_BITS'((COEF_PCT[ch][stage] * 65536 + 50) / 100);
  endfunction

endpackage

// File: design/sapd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sapd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/sapd_lane.sv
// One channel lane: a sequencer that runs the allpass cascade over a shared multiplier.
`include "stereo_allpass_diffuser_macros.svh"

module sapd_lane #(
  parameter int CHANNEL        = 0,
  parameter int SAMPLE_RATE_HZ = 48000,
  parameter int STAGE_COUNT    = 6,
  parameter int SAMPLE_BITS    = 24,
  parameter int FRACTION_BITS  = 21
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [SAMPLE_BITS-1:0]  x_in,
  input  logic                           take,
  output sapd_pkg::sapd_lane_stat_t      stat,
  output logic signed [SAMPLE_BITS-1:0]  y_out
);
  import sapd_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_SUB   = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;
  localparam logic [2:0] ST_HOLD  = 3'd6;

  localparam int STAGES_USED = (STAGE_COUNT > MAX_STAGES) ? MAX_STAGES : STAGE_COUNT;
  localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGES_USED - 1);

  // Delay line layout, worked out at elaboration.
  localparam int unsigned LINE_LEN [MAX_STAGES] = '{
    sapd_line_len(CHANNEL, 0, SAMPLE_RATE_HZ), sapd_line_len(CHANNEL, 1, SAMPLE_RATE_HZ),
    sapd_line_len(CHANNEL, 2, SAMPLE_RATE_HZ), sapd_line_len(CHANNEL, 3, SAMPLE_RATE_HZ),
    sapd_line_len(CHANNEL, 4, SAMPLE_RATE_HZ), sapd_line_len(CHANNEL, 5, SAMPLE_RATE_HZ)
  };
  localparam int unsigned LINE_BASE [MAX_STAGES] = '{
    sapd_line_base(CHANNEL, 0, SAMPLE_RATE_HZ), sapd_line_base(CHANNEL, 1, SAMPLE_RATE_HZ),
    sapd_line_base(CHANNEL, 2, SAMPLE_RATE_HZ), sapd_line_base(CHANNEL, 3, SAMPLE_RATE_HZ),
    sapd_line_base(CHANNEL, 4, SAMPLE_RATE_HZ), sapd_line_base(CHANNEL, 5, SAMPLE_RATE_HZ)
  };
  localparam logic [COEF_BITS-1:0] COEF [MAX_STAGES] = '{
    sapd_coef(CHANNEL, 0), sapd_coef(CHANNEL, 1), sapd_coef(CHANNEL, 2),
    sapd_coef(CHANNEL, 3), sapd_coef(CHANNEL, 4), sapd_coef(CHANNEL, 5)
  };

  localparam int unsigned DEPTH   = LINE_BASE[STAGES_USED-1] + LINE_LEN[STAGES_USED-1];
  localparam int unsigned MAX_LEN = sapd_max_len(CHANNEL, SAMPLE_RATE_HZ, STAGES_USED);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SW     = SAMPLE_BITS + 2;
  localparam int PW     = SAMPLE_BITS + COEF_BITS + 1;

  // Saturation rails: plus or minus four, bounded by the sample range.
  localparam longint SAT_CAP  = longint'(4) << FRACTION_BITS;
  localparam longint RAIL_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint HI_L     = (SAT_CAP > RAIL_MAX) ? RAIL_MAX : SAT_CAP;
  localparam longint LO_L     = (-SAT_CAP < -RAIL_MAX - 1) ? -RAIL_MAX - 1 : -SAT_CAP;
  localparam logic signed [SW-1:0] SAT_HI   = SW'(HI_L);
  localparam logic signed [SW-1:0] SAT_LO   = SW'(LO_L);
  localparam logic signed [PW-1:0] RND_HALF = PW'(longint'(1) << (COEF_BITS - 1));

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SAT_HI) return SAMPLE_BITS'(SAT_HI);
    if (v < SAT_LO) return SAMPLE_BITS'(SAT_LO);
    return SAMPLE_BITS'(v);
  endfunction

  logic [2:0]                     state_r, state_nxt;
  logic [STAGE_W-1:0]             stage_r, stage_nxt;
  logic [POS_W-1:0]               pos_r [MAX_STAGES];
  logic [POS_W-1:0]               pos_nxt [MAX_STAGES];
  logic [MAX_STAGES-1:0]          wrap_r, wrap_nxt;
  logic signed [SAMPLE_BITS-1:0]  x_r, x_nxt;
  logic signed [SAMPLE_BITS-1:0]  d_r, d_nxt;
  logic signed [SAMPLE_BITS-1:0]  y_r, y_nxt;
  logic signed [PW-1:0]           prod_r, prod_nxt;

  logic [POS_W-1:0]               cur_pos;
  logic [POS_W-1:0]               last_pos;
  logic [ADDR_W-1:0]              addr;
  logic [SAMPLE_BITS-1:0]         rdata;
  logic                           we;
  logic signed [SAMPLE_BITS-1:0]  wdata;
  logic signed [SAMPLE_BITS-1:0]  mul_a;
  logic signed [PW-1:0]           rnd_full;
  logic signed [SW-1:0]           rnd;

  // Position and address of the current stage's tap.
  assign cur_pos  = pos_r[stage_r];
  assign last_pos = POS_W'(LINE_LEN[stage_r] - 1);
  assign addr     = ADDR_W'(LINE_BASE[stage_r]) + ADDR_W'(cur_pos);

  // Shared multiplier operand and product rounding, half toward plus infinity.
  assign mul_a    = (state_r == ST_MUL2) ? y_r : x_r;
  assign rnd_full = (prod_r + RND_HALF) >>> COEF_BITS;
  assign rnd      = $signed(rnd_full[SW-1:0]);

  // Feedback value written back into the delay line.
  assign we    = (state_r == ST_WRITE);
  assign wdata = sat(SW'(x_r) + rnd);

  sapd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  // Sequencer: read tap, feedforward product, stage output, feedback product, write back.
  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    pos_nxt   = pos_r;
    wrap_nxt  = wrap_r;
    x_nxt     = x_r;
    d_nxt     = d_r;
    y_nxt     = y_r;
    prod_nxt  = prod_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt     = sat(SW'(x_in));
          stage_nxt = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        // A line that has not wrapped yet is read as zero, since the store itself is never cleared.
        d_nxt     = wrap_r[stage_r] ? $signed(rdata) : '0;
        prod_nxt  = mul_a * $signed({1'b0, COEF[stage_r]});
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        y_nxt     = sat(SW'(d_r) - rnd);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod_nxt  = mul_a * $signed({1'b0, COEF[stage_r]});
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (cur_pos == last_pos) begin
          pos_nxt[stage_r]  = '0;
          wrap_nxt[stage_r] = 1'b1;
        end else begin
          pos_nxt[stage_r] = cur_pos + 1'b1;
        end
        x_nxt = y_r;
        if (stage_r == LAST_STAGE) begin
          state_nxt = ST_HOLD;
        end else begin
          stage_nxt = stage_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_HOLD: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stage_r <= '0;
      wrap_r  <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      wrap_r  <= wrap_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    d_r    <= d_nxt;
    y_r    <= y_nxt;
    prod_r <= prod_nxt;
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.full = (state_r == ST_HOLD);
  assign y_out     = x_r;

  `SAPD_ASSERT(a_pos_in_line, cur_pos <= last_pos, "stage position beyond its line length")
  `SAPD_ASSERT(a_start_when_idle, !start || (state_r == ST_IDLE), "lane started while busy")
  `SAPD_ASSERT_NEXT(a_last_write_holds, (state_r == ST_WRITE) && (stage_r == LAST_STAGE), state_r == ST_HOLD, "last stage did not end in hold")

endmodule

// File: design/sapd_merge.sv
// Merge stage: pairs the lane results into the output register and paces the input.
`include "stereo_allpass_diffuser_macros.svh"

module sapd_merge #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic                           start,
  input  sapd_pkg::sapd_lane_stat_t      l_stat,
  input  sapd_pkg::sapd_lane_stat_t      r_stat,
  input  logic signed [SAMPLE_BITS-1:0]  l_y,
  input  logic signed [SAMPLE_BITS-1:0]  r_y,
  output logic                           take,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_left,
  output logic signed [SAMPLE_BITS-1:0]  out_right
);
  import sapd_pkg::*;

  logic                          valid_r, valid_nxt;
  logic signed [SAMPLE_BITS-1:0] left_r, right_r;

  // A new request enters only when both lanes are free.
  assign in_stall = !(l_stat.idle && r_stat.idle);
  assign start    = in_valid && !in_stall;

  // Both results move into the output register once it is empty or being drained.
  assign take = l_stat.full && r_stat.full && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_r  <= l_y;
      right_r <= r_y;
    end
  end

  assign out_valid = valid_r;
  assign out_left  = left_r;
  assign out_right = right_r;

  `SAPD_ASSERT(a_take_needs_both, !take || (l_stat.full && r_stat.full), "result taken from a busy lane")
  `SAPD_ASSERT(a_lanes_lockstep, (l_stat.idle == r_stat.idle) && (l_stat.full == r_stat.full), "lanes out of step")
  `SAPD_ASSERT_NEXT(a_take_shows, take, out_valid, "taken result not presented")

endmodule

// File: design/stereo_allpass_diffuser.sv
// Stereo allpass diffuser top level. Each accepted request carries one stereo frame of
// signed fixed-point samples; the left and right lanes each run six (STAGE_COUNT)
// Schroeder allpass stages, one after another, on one shared multiplier and one delay
// store per lane. Each stage steps through tap read, feedforward product, stage output,
// feedback product and write back, and the finished frame waits in the lanes until the
// output register takes it. A new frame is accepted only once both lanes are idle again,
// so the lane sequencer and its multiplier limit the input rate. Delay line lengths
// are odd primes fixed at elaboration from SAMPLE_RATE_HZ; the delay stores need no
// clearing pass after reset, since each line reads as zero until its position has
// wrapped once. Outputs saturate at the rails.
module stereo_allpass_diffuser #(
  parameter int SAMPLE_RATE_HZ = sapd_pkg::DEF_SAMPLE_RATE_HZ,
  parameter int STAGE_COUNT    = sapd_pkg::DEF_STAGE_COUNT,
  parameter int SAMPLE_BITS    = sapd_pkg::DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS  = sapd_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]  in_right_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_left_out,
  output logic signed [SAMPLE_BITS-1:0]  out_right_out
);
  import sapd_pkg::*;

  sapd_lane_stat_t               l_stat, r_stat;
  logic signed [SAMPLE_BITS-1:0] l_y, r_y;
  logic                          start;
  logic                          take;

  // Left channel lane.
  sapd_lane #(
    .CHANNEL        (CH_LEFT),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
    .STAGE_COUNT    (STAGE_COUNT),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .x_in  (in_left_in),
    .take  (take),
    .stat  (l_stat),
    .y_out (l_y)
  );

  // Right channel lane.
  sapd_lane #(
    .CHANNEL        (CH_RIGHT),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
    .STAGE_COUNT    (STAGE_COUNT),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .x_in  (in_right_in),
    .take  (take),
    .stat  (r_stat),
    .y_out (r_y)
  );

  // Output register and input pacing.
  sapd_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start     (start),
    .l_stat    (l_stat),
    .r_stat    (r_stat),
    .l_y       (l_y),
    .r_y       (r_y),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left_out),
    .out_right (out_right_out)
  );

endmodule

// File: tb/diffuser_tb_pkg.sv
// Scoreboard class with a bit-exact predictor of the stereo allpass diffuser.
package diffuser_tb_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int STAGES      = 6;
  localparam int LINE_SPAN   = 1024;
  localparam longint RAIL_HI = 64'sd8388607;
  localparam longint RAIL_LO = -64'sd8388608;

  class allpass_scoreboard;
    int unsigned line_len [2][STAGES];
    int unsigned gain_pct [2][STAGES];
    longint      line_gain[2][STAGES];
    int unsigned tap_pos  [2][STAGES];
    longint      echo_mem [2][STAGES][LINE_SPAN];
    logic signed [SAMPLE_W-1:0] want_left[$];
    logic signed [SAMPLE_W-1:0] want_right[$];
    int          errors;

    function new();
      // Odd-prime line lengths at 48 kHz and gains in percent.
      line_len = '{'{73, 127, 191, 281, 409, 601}, '{79, 127, 193, 283, 409, 607}};
      gain_pct = '{'{65, 62, 59, 56, 53, 50}, '{63, 60, 58, 55, 52, 49}};
      errors   = 0;
      for (int ch = 0; ch < 2; ch++) begin
        for (int s = 0; s < STAGES; s++) begin
          // Unsigned Q0.16 gain, rounded half up.
          line_gain[ch][s] = longint'((gain_pct[ch][s] * 65536 + 50) / 100);
          tap_pos[ch][s]   = 0;
          for (int i = 0; i < LINE_SPAN; i++) echo_mem[ch][s][i] = 0;
        end
      end
    endfunction

    // Saturation at the rails of the 24-bit sample format.
    function longint clamp_rail(longint v);
      if (v > RAIL_HI) return RAIL_HI;
      if (v < RAIL_LO) return RAIL_LO;
      return v;
    endfunction

    // Gain product rounded half toward plus infinity back to the sample format.
    function longint gain_product(longint x, longint g);
      longint q;
      q = x * g + 64'sd32768;
      return q >>> 16;
    endfunction

    // One channel through the whole allpass cascade, updating the delay lines.
    function longint diffuse_channel(int ch, longint x);
      longint y;
      int unsigned p;
      x = clamp_rail(x);
      for (int s = 0; s < STAGES; s++) begin
        p = tap_pos[ch][s];
        y = clamp_rail(echo_mem[ch][s][p] - gain_product(x, line_gain[ch][s]));
        echo_mem[ch][s][p] = clamp_rail(x + gain_product(y, line_gain[ch][s]));
        tap_pos[ch][s] = (p + 1 >= line_len[ch][s]) ? 0 : p + 1;
        x = y;
      end
      return clamp_rail(x);
    endfunction

    // An accepted frame request: work out the diffused frame it must produce.
    function void note_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      want_left.push_back(SAMPLE_W'(diffuse_channel(0, longint'(l))));
      want_right.push_back(SAMPLE_W'(diffuse_channel(1, longint'(r))));
    endfunction

    // An accepted result request: compare it with the oldest expected frame.
    function void check_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      logic signed [SAMPLE_W-1:0] el;
      logic signed [SAMPLE_W-1:0] er;
      if (want_left.size() == 0) begin
        $error("unexpected output frame left_out=%0d right_out=%0d", l, r);
        errors++;
        return;
      end
      el = want_left.pop_front();
      er = want_right.pop_front();
      if (l !== el) begin
        $error("left_out mismatch: expected %0d, actual %0d", el, l);
        errors++;
      end
      if (r !== er) begin
        $error("right_out mismatch: expected %0d, actual %0d", er, r);
        errors++;
      end
    endfunction

    function int pending();
      return want_left.size();
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench of the stereo allpass diffuser with random idling and back-pressure.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import diffuser_tb_pkg::*;

  localparam int RANDOM_FRAMES = 1900;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 40;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh800000;
  localparam logic signed [SAMPLE_W-1:0] S_ONE = 24'sh200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_left_in = '0;
  logic signed [SAMPLE_W-1:0] in_right_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left_out;
  logic signed [SAMPLE_W-1:0] out_right_out;

  // Idling controls and long-hold requests set by the stimulus process.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int holds_asked = 0;
  int idle_run = 0;

  allpass_scoreboard sb = new();

  stereo_allpass_diffuser u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out)
  );

  always #1 clk = ~clk;

  // Offer one frame request, with random idle cycles ahead of it.
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
    while (tx_idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_left_in  <= l;
    in_right_in <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A random sample: full range, a rail, or a small value near zero.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0, 1: return SAMPLE_W'($urandom);
      2: return $urandom_range(1) ? S_MAX : S_MIN;
      default: return SAMPLE_W'(int'($urandom_range(2047)) - 1024);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold whenever one is asked for.
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_asked > holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(99) < 35);
      end
    end
  end

  // Monitor both channels and watch for a stuck handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_frame(in_left_in, in_right_in);
      if (out_valid && !out_stall) sb.check_frame(out_left_out, out_right_out);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
      if (idle_run >= WATCHDOG_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus: directed frames first, then random frames over several idling phases.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Silence, the rails, opposite rails and unit impulses.
    send_frame('0, '0);
    send_frame(S_MAX, S_MAX);
    send_frame(S_MIN, S_MIN);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(24'sd1, -24'sd1);
    send_frame(-24'sd1, 24'sd1);
    send_frame(S_ONE, '0);
    send_frame('0, -S_ONE);
    // Sustained full scale drives the internal stages into saturation.
    repeat (4) send_frame(S_MAX, S_MIN);
    // Alternating rails push the stage outputs past both limits.
    for (int i = 0; i < 6; i++) begin
      send_frame(i[0] ? S_MAX : S_MIN, i[0] ? S_MIN : S_MAX);
    end
    send_frame(24'sh555555, 24'shAAAAAA);
    send_frame(24'shAAAAAA, 24'sh555555);

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      // A long stretch with no idling on either side.
      if (n == 600) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (n == 1000) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      // The receiver holds off while the sender keeps offering frames.
      if (n == 1100 || n == 1600) holds_asked++;
      send_frame(pick_sample(), pick_sample());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/sapd_pkg.sv
design/sapd_ram.sv
design/sapd_lane.sv
design/sapd_merge.sv
design/stereo_allpass_diffuser.sv
tb/diffuser_tb_pkg.sv
tb/tb_top.sv
